### hw/rtl/spnh_pkg.sv
// Shared types, constants and state encoding for the segment/polygon nearest-hit block.
package spnh_pkg;

    localparam int unsigned RATIO_SCALE_DEF = 100;
    localparam int unsigned DIST_W = 34;
    localparam logic [DIST_W-1:0] DIST_INIT = 34'd999999999;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_W = 35;
    localparam int unsigned QUOT_W = 46;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y = 2'd3;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               last_vertex;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         hit_count;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic               point_valid;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_NUM,
        ST_DIV1,
        ST_CHK1,
        ST_DIV2,
        ST_CHK2,
        ST_HMUL,
        ST_HDIV,
        ST_DIST,
        ST_UPD,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input vertex
        logic prod;       // edge deltas and products
        logic num;        // numerators and denominator
        logic div_start1;
        logic div_start2;
        logic hmul;
        logic hscale;     // hit-point offsets scaled by 1/RATIO_SCALE
        logic hpt;        // hit point and squared distance
        logic update;     // count and best update
        logic advance;    // prev <= vertex
        logic clear;      // end of polygon
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic have_prev;
        logic denom_zero;
        logic div_busy;
        logic ratio_ok;
        logic last;
        logic out_full;
    } t_status;

endpackage

### hw/rtl/spnh_div.sv
// Restoring serial divider: signed quotient truncated toward zero, one bit per cycle.
module spnh_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [spnh_pkg::QUOT_W-1:0]    i_numer,
    input  logic signed [spnh_pkg::QUOT_W-1:0]    i_denom,
    output logic                                  o_busy,
    output logic signed [spnh_pkg::QUOT_W-1:0]    o_quot
);
    import spnh_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0] r_rem, n_rem;
    logic [QUOT_W-1:0] r_q, n_q;
    logic [QUOT_W-1:0] r_dv;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [QUOT_W:0]   w_trial;
    logic [QUOT_W-1:0] w_shift;

    assign w_shift = {r_rem[QUOT_W-2:0], r_q[QUOT_W-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_dv};

    always_comb begin
        n_q = {r_q[QUOT_W-2:0], 1'b0};
        n_rem = w_shift;
        if (!w_trial[QUOT_W]) begin
            n_rem = w_trial[QUOT_W-1:0];
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q <= i_numer[QUOT_W-1] ? -i_numer : i_numer;
            r_dv <= i_denom[QUOT_W-1] ? -i_denom : i_denom;
            r_neg <= i_numer[QUOT_W-1] ^ i_denom[QUOT_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

### hw/rtl/spnh_ctrl.sv
// Sequencer for one vertex: edge test, nearest-hit update and result emit.
module spnh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  spnh_pkg::t_status i_status,
    output spnh_pkg::t_cmd    o_cmd
);
    import spnh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_PROD;
                end
            end
            ST_PROD: begin
                if (!i_status.have_prev) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.prod = 1'b1;
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (i_status.denom_zero) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_start1 = 1'b1;
                    n_state = ST_CHK1;
                end
            end
            ST_CHK1: begin
                if (!i_status.div_busy) n_state = i_status.ratio_ok ? ST_DIV2 : ST_DONE;
            end
            ST_DIV2: begin
                o_cmd.div_start2 = 1'b1;
                n_state = ST_CHK2;
            end
            ST_CHK2: begin
                if (!i_status.div_busy) n_state = i_status.ratio_ok ? ST_HMUL : ST_DONE;
            end
            ST_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state = ST_HDIV;
            end
            ST_HDIV: begin
                o_cmd.hscale = 1'b1;
                n_state = ST_DIST;
            end
            ST_DIST: begin
                o_cmd.hpt = 1'b1;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.last) begin
                    o_cmd.advance = 1'b1;
                    n_state = ST_IDLE;
                end else if (!i_status.out_full) begin
                    o_cmd.advance = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

### hw/rtl/spnh_dp.sv
// Datapath: segment registers, edge products, shared divider and best-hit state.
module spnh_dp #(
    parameter int unsigned RATIO_SCALE = spnh_pkg::RATIO_SCALE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spnh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spnh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  spnh_pkg::t_in_word                i_in_data,
    input  spnh_pkg::t_cmd                    i_cmd,
    output spnh_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output spnh_pkg::t_out_word               o_out_data
);
    import spnh_pkg::*;

    localparam int unsigned RS_W = $clog2(RATIO_SCALE + 1) + 1;
    localparam logic signed [RS_W-1:0] RS = RS_W'(RATIO_SCALE);

    // ratio * |delta| < 2^HM_W; floor(m * RCP_K / 2^RCP_SH) == floor(m / RATIO_SCALE)
    // holds for every m below 2^HM_W
    localparam int unsigned LOG_RS = $clog2(RATIO_SCALE);
    localparam int unsigned HM_W = LOG_RS + 16;
    localparam int unsigned RCP_SH = 2 * LOG_RS + 16;
    localparam int unsigned RCP_W = LOG_RS + 18;
    localparam int unsigned HP_W = HM_W + RCP_W;
    localparam logic [63:0] RCP_K64 = ((64'd1 << RCP_SH) / 64'(RATIO_SCALE)) + 64'd1;
    localparam logic [RCP_W-1:0] RCP_K = RCP_K64[RCP_W-1:0];

    logic signed [15:0] r_sx, r_sy, r_ex, r_ey;
    logic signed [15:0] r_vx, r_vy, r_px, r_py;
    logic               r_last, r_have_prev;
    logic signed [16:0] r_d1x, r_d1y;
    logic signed [33:0] r_p_a, r_p_b, r_p_c, r_p_d, r_p_e, r_p_f;
    logic signed [NUM_W-1:0] r_n1, r_n2, r_den;
    logic [RS_W-2:0]    r_r1;
    logic [HM_W-1:0]    r_hmx, r_hmy;
    logic               r_sgx, r_sgy;
    logic [16:0]        r_hqx, r_hqy;
    logic signed [15:0] r_hx, r_hy;
    logic [DIST_W-1:0]  r_dist, r_best_dist;
    logic signed [15:0] r_bx, r_by;
    logic               r_bvalid;
    logic [7:0]         r_cnt;
    logic               r_out_valid;
    t_out_word          r_out;

    logic                    w_start;
    logic signed [QUOT_W-1:0] w_numer, w_denom, w_quot;
    logic                    w_busy;
    logic signed [16:0]      w_d2x, w_d2y;
    logic [16:0]             w_ad1x, w_ad1y;
    logic [HM_W-1:0]         w_hmx, w_hmy;
    logic [HP_W-1:0]         w_hpx, w_hpy;
    logic signed [16:0]      w_hqx, w_hqy;
    logic [33:0]             w_sqx, w_sqy;

    assign w_d2x = 17'(r_vx) - 17'(r_px);
    assign w_d2y = 17'(r_vy) - 17'(r_py);

    // divider is shared by both ratios
    always_comb begin
        w_start = i_cmd.div_start1 | i_cmd.div_start2;
        w_numer = RS * QUOT_W'(r_n1);
        w_denom = QUOT_W'(r_den);
        if (i_cmd.div_start2) w_numer = RS * QUOT_W'(r_n2);
    end

    spnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_numer (w_numer),
        .i_denom (w_denom),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_ex <= '0; r_ey <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SEG_START_X: r_sx <= i_cfg_data;
                REG_SEG_START_Y: r_sy <= i_cfg_data;
                REG_SEG_END_X:   r_ex <= i_cfg_data;
                REG_SEG_END_Y:   r_ey <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_cnt <= '0;
            r_best_dist <= DIST_INIT;
            r_bvalid <= 1'b0;
            r_bx <= '0; r_by <= '0;
            r_px <= '0; r_py <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.update) begin
                if (r_cnt != 8'hFF) r_cnt <= r_cnt + 1'b1;
                if (r_dist < r_best_dist) begin
                    r_best_dist <= r_dist;
                    r_bx <= r_hx; r_by <= r_hy;
                    r_bvalid <= 1'b1;
                end
            end
            if (i_cmd.advance) begin
                r_px <= r_vx; r_py <= r_vy;
                r_have_prev <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out.hit_count <= r_cnt;
                r_out.hit_x <= r_bvalid ? r_bx : '0;
                r_out.hit_y <= r_bvalid ? r_by : '0;
                r_out.point_valid <= r_bvalid;
            end
            if (i_cmd.clear) begin
                r_have_prev <= 1'b0;
                r_cnt <= '0;
                r_best_dist <= DIST_INIT;
                r_bvalid <= 1'b0;
            end
        end
    end

    // ratio is 0..RATIO_SCALE here, so magnitudes stay small
    assign w_ad1x = r_d1x[16] ? 17'(-r_d1x) : 17'(r_d1x);
    assign w_ad1y = r_d1y[16] ? 17'(-r_d1y) : 17'(r_d1y);
    assign w_hmx = HM_W'(r_r1) * HM_W'(w_ad1x);
    assign w_hmy = HM_W'(r_r1) * HM_W'(w_ad1y);
    assign w_hpx = HP_W'(r_hmx) * HP_W'(RCP_K);
    assign w_hpy = HP_W'(r_hmy) * HP_W'(RCP_K);
    assign w_hqx = r_sgx ? -$signed(r_hqx) : $signed(r_hqx);
    assign w_hqy = r_sgy ? -$signed(r_hqy) : $signed(r_hqy);
    assign w_sqx = 34'(r_hqx) * 34'(r_hqx);
    assign w_sqy = 34'(r_hqy) * 34'(r_hqy);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= i_in_data.vertex_x;
            r_vy <= i_in_data.vertex_y;
            r_last <= i_in_data.last_vertex;
        end
        if (i_cmd.prod) begin
            r_d1x <= 17'(r_ex) - 17'(r_sx);
            r_d1y <= 17'(r_ey) - 17'(r_sy);
            r_p_a <= (17'(r_ex) - 17'(r_sx)) * w_d2y;
            r_p_b <= (17'(r_ey) - 17'(r_sy)) * w_d2x;
            r_p_c <= (17'(r_sy) - 17'(r_py)) * w_d2x;
            r_p_d <= (17'(r_sx) - 17'(r_px)) * w_d2y;
            r_p_e <= (17'(r_sy) - 17'(r_py)) * (17'(r_ex) - 17'(r_sx));
            r_p_f <= (17'(r_sx) - 17'(r_px)) * (17'(r_ey) - 17'(r_sy));
        end
        if (i_cmd.num) begin
            r_den <= NUM_W'(r_p_a) - NUM_W'(r_p_b);
            r_n1 <= NUM_W'(r_p_c) - NUM_W'(r_p_d);
            r_n2 <= NUM_W'(r_p_e) - NUM_W'(r_p_f);
        end
        if (i_cmd.div_start2) r_r1 <= w_quot[RS_W-2:0];
        if (i_cmd.hmul) begin
            r_hmx <= w_hmx;
            r_hmy <= w_hmy;
            r_sgx <= r_d1x[16];
            r_sgy <= r_d1y[16];
        end
        if (i_cmd.hscale) begin
            r_hqx <= w_hpx[RCP_SH +: 17];
            r_hqy <= w_hpy[RCP_SH +: 17];
        end
        if (i_cmd.hpt) begin
            r_hx <= 16'(17'(r_sx) + w_hqx);
            r_hy <= 16'(17'(r_sy) + w_hqy);
            r_dist <= w_sqx + w_sqy;
        end
    end

    assign o_status.have_prev = r_have_prev;
    assign o_status.denom_zero = (r_den == '0);
    assign o_status.div_busy = w_busy | w_start;
    assign o_status.ratio_ok = !w_quot[QUOT_W-1] && (w_quot <= QUOT_W'(RS));
    assign o_status.last = r_last;
    assign o_status.out_full = r_out_valid & i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
endmodule

### hw/rtl/segment_polygon_nearest_hit_top.sv
// Top level: segment/polygon nearest-hit block.
// One vertex word is taken at a time. The first vertex of a polygon is only stored; a parallel
// edge stops before any division, an edge that misses on a ratio stops after that ratio's
// division, and a hit goes on to the hit point and update. One 46-bit serial divider (one
// quotient bit per cycle) is shared by the two ratios; the hit point is scaled by a reciprocal
// multiply. The result word sits in an output register, so the next polygon may start while it
// waits to be taken; a last vertex holds until the previous result word has been taken.
module segment_polygon_nearest_hit_top #(
    parameter int unsigned RATIO_SCALE = spnh_pkg::RATIO_SCALE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spnh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spnh_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  spnh_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output spnh_pkg::t_out_word             o_out_data
);
    import spnh_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    spnh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    spnh_dp #(.RATIO_SCALE(RATIO_SCALE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_emit_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.last) else $error("emit without last vertex");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.prod || w_cmd.update) |-> o_in_stall) else $error("input taken mid-edge");
    a_point_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_out_data.point_valid |-> o_out_data.hit_count != 8'd0)
        else $error("point without hit");
endmodule
